>>> hw/rtl/cse_pkg.sv
// Shared types, byte codes and defaults for the comment span extractor.
`timescale 1ns / 1ps

package cse_pkg;

   // Default counter width and queue depth
   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned OUT_WIDTH           = 16;

   // Delimiter byte codes
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Byte class as seen by the scanner
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_SLASH,
      CLS_STAR,
      CLS_QUOTE,
      CLS_BSLASH,
      CLS_NEWLINE
   } char_class_type;

   // Scanner mode
   typedef enum logic [2:0] {
      MODE_TEXT,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_STAR,
      MODE_QUOTE,
      MODE_ESCAPE
   } scan_mode_type;

   // One classified word travelling from front to back
   typedef struct packed {
      logic           frame_start;
      char_class_type cls;
   } item_type;

endpackage

>>> hw/rtl/cse_front.sv
// Front end: accepts text bytes and classifies them for the scanner.
`timescale 1ns / 1ps

module cse_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_ch,
   input  logic              req_frame_start,
   output logic              push_valid,
   input  logic              push_ready,
   output cse_pkg::item_type push_item
);

   cse_pkg::char_class_type cls;

   // Decode the byte into its delimiter class
   always_comb begin
      unique case (req_ch)
         cse_pkg::CH_SLASH:   cls = cse_pkg::CLS_SLASH;
         cse_pkg::CH_STAR:    cls = cse_pkg::CLS_STAR;
         cse_pkg::CH_QUOTE:   cls = cse_pkg::CLS_QUOTE;
         cse_pkg::CH_BSLASH:  cls = cse_pkg::CLS_BSLASH;
         cse_pkg::CH_NEWLINE: cls = cse_pkg::CLS_NEWLINE;
         default:             cls = cse_pkg::CLS_OTHER;
      endcase
   end

   // Pass the word on whenever the queue has room
   assign req_ready              = push_ready;
   assign push_valid             = req_valid;
   assign push_item.frame_start  = req_frame_start;
   assign push_item.cls          = cls;

endmodule

>>> hw/rtl/cse_queue.sv
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module cse_queue #(
   parameter int unsigned QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cse_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cse_pkg::item_type pop_item
);

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   cse_pkg::item_type slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/cse_back.sv
// Back end: comment scanner state machine, counters and result register.
`timescale 1ns / 1ps

module cse_back #(
   parameter int unsigned COUNT_WIDTH = cse_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cse_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_body_offset,
   output logic [15:0]       rsp_body_length,
   output logic [15:0]       rsp_body_line
);

   localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

   cse_pkg::scan_mode_type mode_ff, mode_in, mode_cur;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in, pos_cur;
   logic [COUNT_WIDTH-1:0] begin_ff, begin_in, begin_cur;
   logic [COUNT_WIDTH-1:0] len_ff, len_in, len_cur;
   logic [COUNT_WIDTH-1:0] line_ff, line_in, line_cur;
   logic [COUNT_WIDTH-1:0] lstart_ff, lstart_in, lstart_cur;
   logic [COUNT_WIDTH-1:0] pos_inc, len_inc, len_inc2, line_inc;
   logic                   do_pop, emit, open, add_one, add_two;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            offset_ff, length_ff, line_out_ff;
   cse_pkg::char_class_type cls;

   assign cls       = pop_item.cls;
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;

   // Frame start restarts the scanner at this byte
   assign mode_cur   = pop_item.frame_start ? cse_pkg::MODE_TEXT : mode_ff;
   assign pos_cur    = pop_item.frame_start ? '0 : pos_ff;
   assign begin_cur  = pop_item.frame_start ? '0 : begin_ff;
   assign len_cur    = pop_item.frame_start ? '0 : len_ff;
   assign line_cur   = pop_item.frame_start ? '0 : line_ff;
   assign lstart_cur = pop_item.frame_start ? '0 : lstart_ff;

   // Saturating increments
   assign pos_inc  = (pos_cur == CntMax) ? CntMax : pos_cur + 1'b1;
   assign line_inc = (line_cur == CntMax) ? CntMax : line_cur + 1'b1;
   assign len_inc  = (len_cur == CntMax) ? CntMax : len_cur + 1'b1;
   assign len_inc2 = (len_cur >= CntMax - 1'b1) ? CntMax : len_cur + 2'd2;

   // Next scanner mode
   always_comb begin
      mode_in = mode_cur;
      unique case (mode_cur)
         cse_pkg::MODE_TEXT: begin
            if (cls == cse_pkg::CLS_SLASH) mode_in = cse_pkg::MODE_SLASH;
            else if (cls == cse_pkg::CLS_QUOTE) mode_in = cse_pkg::MODE_QUOTE;
         end
         cse_pkg::MODE_SLASH: begin
            if (cls == cse_pkg::CLS_SLASH) mode_in = cse_pkg::MODE_LINE;
            else if (cls == cse_pkg::CLS_STAR) mode_in = cse_pkg::MODE_BLOCK;
            else if (cls == cse_pkg::CLS_QUOTE) mode_in = cse_pkg::MODE_QUOTE;
            else mode_in = cse_pkg::MODE_TEXT;
         end
         cse_pkg::MODE_LINE: begin
            if (cls == cse_pkg::CLS_NEWLINE) mode_in = cse_pkg::MODE_TEXT;
         end
         cse_pkg::MODE_BLOCK: begin
            if (cls == cse_pkg::CLS_STAR) mode_in = cse_pkg::MODE_STAR;
         end
         cse_pkg::MODE_STAR: begin
            if (cls == cse_pkg::CLS_SLASH) mode_in = cse_pkg::MODE_TEXT;
            else if (cls != cse_pkg::CLS_STAR) mode_in = cse_pkg::MODE_BLOCK;
         end
         cse_pkg::MODE_QUOTE: begin
            if (cls == cse_pkg::CLS_QUOTE) mode_in = cse_pkg::MODE_TEXT;
            else if (cls == cse_pkg::CLS_BSLASH) mode_in = cse_pkg::MODE_ESCAPE;
         end
         cse_pkg::MODE_ESCAPE: mode_in = cse_pkg::MODE_QUOTE;
         default: mode_in = cse_pkg::MODE_TEXT;
      endcase
   end

   // Scanner actions: open a comment, grow its body, or finish it
   always_comb begin
      emit    = 1'b0;
      open    = 1'b0;
      add_one = 1'b0;
      add_two = 1'b0;
      unique case (mode_cur)
         cse_pkg::MODE_SLASH: begin
            open = (cls == cse_pkg::CLS_SLASH) || (cls == cse_pkg::CLS_STAR);
         end
         cse_pkg::MODE_LINE: begin
            emit    = (cls == cse_pkg::CLS_NEWLINE);
            add_one = (cls != cse_pkg::CLS_NEWLINE);
         end
         cse_pkg::MODE_BLOCK: begin
            add_one = (cls != cse_pkg::CLS_STAR);
         end
         cse_pkg::MODE_STAR: begin
            emit    = (cls == cse_pkg::CLS_SLASH);
            add_one = (cls == cse_pkg::CLS_STAR);
            add_two = (cls != cse_pkg::CLS_SLASH) && (cls != cse_pkg::CLS_STAR);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Counter updates for the current word
   always_comb begin
      pos_in    = pos_inc;
      line_in   = (cls == cse_pkg::CLS_NEWLINE) ? line_inc : line_cur;
      begin_in  = open ? pos_inc : begin_cur;
      lstart_in = open ? line_cur : lstart_cur;
      if (open || emit) begin
         len_in = '0;
      end else if (add_two) begin
         len_in = len_inc2;
      end else if (add_one) begin
         len_in = len_inc;
      end else begin
         len_in = len_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cse_pkg::MODE_TEXT;
         pos_ff    <= '0;
         begin_ff  <= '0;
         len_ff    <= '0;
         line_ff   <= '0;
         lstart_ff <= '0;
      end else if (do_pop) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         len_ff    <= len_in;
         line_ff   <= line_in;
         lstart_ff <= lstart_in;
      end
   end

   // Hold a finished result until the consumer takes it
   assign rsp_valid_in = (do_pop && emit) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop && emit) begin
         offset_ff   <= 16'(begin_cur);
         length_ff   <= 16'(len_cur);
         line_out_ff <= 16'(lstart_cur);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_body_offset = offset_ff;
   assign rsp_body_length = length_ff;
   assign rsp_body_line   = line_out_ff;

endmodule

>>> hw/rtl/comment_span_extractor_top.sv
// A closing byte is queued; its result is registered when the scanner takes the byte.
// Throughput: one text byte per cycle; a four-word queue decouples intake from the scanner.
// A stalled result register holds the scanner; intake stops only when the queue is full.
// Reset (synchronous, active high) empties the queue, drops any held result and
// returns the scanner to plain text with all counters at zero.
`timescale 1ns / 1ps

module comment_span_extractor_top #(
   parameter int unsigned COUNT_WIDTH = cse_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_body_offset,
   output logic [15:0] rsp_body_length,
   output logic [15:0] rsp_body_line
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   cse_pkg::item_type push_item, pop_item;

   // Classify incoming bytes
   cse_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_frame_start (req_frame_start),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   // Buffer classified words
   cse_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Scan and report comment spans
   cse_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_item        (pop_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_body_offset (rsp_body_offset),
      .rsp_body_length (rsp_body_length),
      .rsp_body_line   (rsp_body_line)
   );

endmodule

>>> hw/rtl/cse_checker.sv
// Port-level checks for the comment span extractor, bound to the top level.
`timescale 1ns / 1ps

module cse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_ch,
   input logic        req_frame_start,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_body_offset,
   input logic [15:0] rsp_body_length,
   input logic [15:0] rsp_body_line
);

   // Hold a waiting text word
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_ch)
         && $stable(req_frame_start))
      else $error("waiting text word changed");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_body_offset)
         && $stable(rsp_body_length) && $stable(rsp_body_line))
      else $error("stalled result word changed");

   // Drop any held result on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid just after reset");

   // Empty queue after reset takes text at once
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("intake not ready just after reset");

   // A body always starts after a two-byte opener
   a_offset_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_body_offset >= 16'd2)
      else $error("comment body offset below two");

endmodule

bind comment_span_extractor_top cse_checker u_cse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_ch          (req_ch),
   .req_frame_start (req_frame_start),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_body_offset (rsp_body_offset),
   .rsp_body_length (rsp_body_length),
   .rsp_body_line   (rsp_body_line)
);

>>> tb/tb_comment_span_extractor_top.sv
// Testbench for the comment span extractor: byte-stream stimulus, span prediction and checking.
`timescale 1ns / 1ps

module tb_comment_span_extractor_top;

   localparam longint unsigned COUNT_MAX = (64'd1 << cse_pkg::COUNT_WIDTH_DEFAULT) - 1;

   typedef struct {
      logic [7:0] ch;
      logic       fs;
   } text_byte_type;

   typedef struct {
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
   } comment_span_type;

   // Tracks the scanner state and holds the comment spans still owed by the block
   class span_scoreboard_type;
      cse_pkg::scan_mode_type mode;
      longint unsigned        position;
      longint unsigned        open_offset;
      longint unsigned        body_len;
      longint unsigned        lines;
      longint unsigned        open_line;
      comment_span_type       pending[$];
      int unsigned            errors;
      int unsigned            spans_checked;
      int unsigned            bytes_seen;
      int unsigned            frames_seen;

      function new();
         restart();
         errors        = 0;
         spans_checked = 0;
         bytes_seen    = 0;
         frames_seen   = 0;
      endfunction

      function void restart();
         mode        = cse_pkg::MODE_TEXT;
         position    = 0;
         open_offset = 0;
         body_len    = 0;
         lines       = 0;
         open_line   = 0;
      endfunction

      function longint unsigned sat_add(longint unsigned a, longint unsigned b);
         return (a + b > COUNT_MAX) ? COUNT_MAX : a + b;
      endfunction

      function void close_comment();
         comment_span_type s;
         s.offset = 16'(open_offset);
         s.length = 16'(body_len);
         s.line   = 16'(open_line);
         pending.push_back(s);
         body_len = 0;
         mode     = cse_pkg::MODE_TEXT;
      endfunction

      // Advance the scanner by one accepted word
      function void note_byte(logic [7:0] ch, logic fs);
         longint unsigned pos;
         bytes_seen++;
         if (fs) begin
            restart();
            frames_seen++;
         end
         pos = position;
         case (mode)
            cse_pkg::MODE_TEXT: begin
               if (ch == cse_pkg::CH_SLASH) mode = cse_pkg::MODE_SLASH;
               else if (ch == cse_pkg::CH_QUOTE) mode = cse_pkg::MODE_QUOTE;
            end
            cse_pkg::MODE_SLASH: begin
               if (ch == cse_pkg::CH_SLASH || ch == cse_pkg::CH_STAR) begin
                  mode        = (ch == cse_pkg::CH_SLASH) ? cse_pkg::MODE_LINE
                                                          : cse_pkg::MODE_BLOCK;
                  open_offset = sat_add(pos, 1);
                  body_len    = 0;
                  open_line   = lines;
               end else if (ch == cse_pkg::CH_QUOTE) begin
                  mode = cse_pkg::MODE_QUOTE;
               end else begin
                  mode = cse_pkg::MODE_TEXT;
               end
            end
            cse_pkg::MODE_LINE: begin
               if (ch == cse_pkg::CH_NEWLINE) close_comment();
               else body_len = sat_add(body_len, 1);
            end
            cse_pkg::MODE_BLOCK: begin
               if (ch == cse_pkg::CH_STAR) mode = cse_pkg::MODE_STAR;
               else body_len = sat_add(body_len, 1);
            end
            cse_pkg::MODE_STAR: begin
               if (ch == cse_pkg::CH_SLASH) begin
                  close_comment();
               end else if (ch == cse_pkg::CH_STAR) begin
                  // hold in the star state, the earlier star is body
                  body_len = sat_add(body_len, 1);
               end else begin
                  body_len = sat_add(body_len, 2);
                  mode     = cse_pkg::MODE_BLOCK;
               end
            end
            cse_pkg::MODE_QUOTE: begin
               if (ch == cse_pkg::CH_QUOTE) mode = cse_pkg::MODE_TEXT;
               else if (ch == cse_pkg::CH_BSLASH) mode = cse_pkg::MODE_ESCAPE;
            end
            cse_pkg::MODE_ESCAPE: mode = cse_pkg::MODE_QUOTE;
            default: mode = cse_pkg::MODE_TEXT;
         endcase
         if (ch == cse_pkg::CH_NEWLINE) lines = sat_add(lines, 1);
         position = sat_add(pos, 1);
      endfunction

      // Compare one delivered span with the oldest one owed
      function void check_span(logic [15:0] offset, logic [15:0] length, logic [15:0] line);
         comment_span_type s;
         if (pending.size() == 0) begin
            $display("%0t: unexpected span offset=%0d length=%0d line=%0d",
                     $time, offset, length, line);
            errors++;
            return;
         end
         s = pending.pop_front();
         spans_checked++;
         if (offset !== s.offset) begin
            $display("%0t: body_offset expected %0d actual %0d", $time, s.offset, offset);
            errors++;
         end
         if (length !== s.length) begin
            $display("%0t: body_length expected %0d actual %0d", $time, s.length, length);
            errors++;
         end
         if (line !== s.line) begin
            $display("%0t: body_line expected %0d actual %0d", $time, s.line, line);
            errors++;
         end
      endfunction
   endclass

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic [7:0]  req_ch          = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_ready       = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [15:0] rsp_body_offset;
   logic [15:0] rsp_body_length;
   logic [15:0] rsp_body_line;

   int unsigned         sender_idle_pct    = 21;
   int unsigned         receiver_stall_pct = 58;
   text_byte_type       text_q[$];
   logic                next_fs            = 1'b0;
   span_scoreboard_type spans              = new();

   comment_span_extractor_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_ch          (req_ch),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_body_offset (rsp_body_offset),
      .rsp_body_length (rsp_body_length),
      .rsp_body_line   (rsp_body_line)
   );

   always #5 clock = ~clock;

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Check every delivered span
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         spans.check_span(rsp_body_offset, rsp_body_length, rsp_body_line);
   end

   // Hard stop on a hang
   initial begin
      #5ms;
      $display("FAIL comment_span_extractor_top");
      $finish;
   end

   function void add_byte(logic [7:0] ch);
      text_byte_type t;
      t.ch    = ch;
      t.fs    = next_fs;
      next_fs = 1'b0;
      text_q.push_back(t);
   endfunction

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function logic [7:0] random_letter();
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   // Comment body byte: delimiters are frequent, newlines only where allowed
   function logic [7:0] body_byte(bit allow_newline);
      logic [7:0] b;
      case ($urandom_range(7))
         0: b = cse_pkg::CH_STAR;
         1: b = cse_pkg::CH_SLASH;
         2: b = cse_pkg::CH_QUOTE;
         3: b = allow_newline ? cse_pkg::CH_NEWLINE : random_letter();
         default: b = 8'($urandom_range(255));
      endcase
      if (!allow_newline && b == cse_pkg::CH_NEWLINE) b = 8'h20;
      return b;
   endfunction

   // Quoted string with escapes and comment-like contents, opening quote included
   function void add_string();
      add_byte(cse_pkg::CH_QUOTE);
      repeat ($urandom_range(6)) begin
         case ($urandom_range(4))
            0: begin
               add_byte(cse_pkg::CH_BSLASH);
               add_byte(8'($urandom_range(255)));
            end
            1: add_byte(cse_pkg::CH_SLASH);
            2: add_byte(cse_pkg::CH_STAR);
            3: add_byte(cse_pkg::CH_NEWLINE);
            default: add_byte(random_letter());
         endcase
      end
      add_byte(cse_pkg::CH_QUOTE);
   endfunction

   // Append one random source fragment, mostly well formed
   function void add_fragment();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 15) begin
         repeat ($urandom_range(6, 1)) add_byte(random_letter());
      end else if (k < 35) begin
         add_text("//");
         repeat ($urandom_range(8)) add_byte(body_byte(1'b0));
         add_byte(cse_pkg::CH_NEWLINE);
      end else if (k < 60) begin
         add_text("/*");
         repeat ($urandom_range(8)) add_byte(body_byte(1'b1));
         repeat ($urandom_range(3, 1)) add_byte(cse_pkg::CH_STAR);
         add_byte(cse_pkg::CH_SLASH);
      end else if (k < 72) begin
         add_string();
      end else if (k < 78) begin
         add_byte(cse_pkg::CH_SLASH);
         add_string();
      end else if (k < 84) begin
         add_byte(cse_pkg::CH_SLASH);
         add_byte(random_letter());
      end else if (k < 88) begin
         add_byte(cse_pkg::CH_NEWLINE);
      end else if (k < 96) begin
         repeat ($urandom_range(4, 1)) add_byte(8'($urandom_range(255)));
      end else begin
         next_fs = 1'b1;
      end
   endfunction

   // Present one word and wait for it to be taken
   task automatic send_byte(input text_byte_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= t.ch;
      req_frame_start <= t.fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      spans.note_byte(t.ch, t.fs);
   endtask

   task automatic drive_text();
      while (text_q.size() != 0) send_byte(text_q.pop_front());
   endtask

   task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                               input int unsigned count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      while (text_q.size() < count) add_fragment();
      drive_text();
   endtask

   initial begin
      int unsigned drain;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed text: extreme bytes, star run, slash then quote, escapes,
      // newline in a string, star then other byte, comment dropped by a new frame
      next_fs = 1'b1;
      add_text("//");
      add_byte(8'hFF);
      add_byte(cse_pkg::CH_NEWLINE);
      add_text("/***/");
      add_text("/\"//\\\"\n\"");
      add_byte(8'h00);
      add_text("/**x*/");
      add_text("/*a");
      next_fs = 1'b1;
      add_text("b//\n");
      drive_text();

      // Random text under three idling patterns
      random_phase(21, 58, 275);
      random_phase(58, 21, 275);
      random_phase(0, 0, 275);
      req_valid <= 1'b0;

      drain = 0;
      while (spans.pending.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);

      if (spans.pending.size() != 0)
         $display("%0t: %0d expected spans never delivered", $time, spans.pending.size());
      $display("Scanned %0d bytes in %0d frames, %0d comment spans checked.",
               spans.bytes_seen, spans.frames_seen, spans.spans_checked);
      $display("Covered strings, escapes, star runs and comments dropped by a new frame.");
      if (spans.errors == 0 && spans.pending.size() == 0) begin
         $display("PASS comment_span_extractor_top");
      end else begin
         $display("FAIL comment_span_extractor_top");
      end
      $finish;
   end

endmodule
